FILE: rtl/cum_pkg.sv
// cum_pkg: shared types and constants of the cpu utilization monitor
// used by cum_div and cpu_utilization_monitor_top; no dependencies
`timescale 1ns / 1ps

package cum_pkg;

    localparam int HISTORY_DEPTH_DEF = 64;
    localparam int UTIL_MAX_DEF      = 10000;

    localparam int UTIL_W   = 14;
    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 16;
    localparam int AVG_W    = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HOG_THRESHOLD = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HOG_LIMIT     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOG_ENABLE    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT     = 8'd3;

    localparam logic [UTIL_W-1:0]  HOG_THRESHOLD_RST = 14'd9900;
    localparam logic [LIMIT_W-1:0] HOG_LIMIT_RST     = 16'd30;
    localparam logic               HOG_ENABLE_RST    = 1'b1;
    localparam logic [AVG_W-1:0]   AVG_COUNT_RST     = 7'd4;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                sample_valid;
    } t_cum_in;

    typedef struct packed {
        logic [UTIL_W-1:0] util_average;
        logic [UTIL_W-1:0] util_peak;
        logic              util_unknown;
        logic              hog_alarm;
    } t_cum_out;

endpackage

FILE: rtl/cum_div.sv
// cum_div: restoring serial divider, one quotient bit per cycle
// depends on cum_pkg
`timescale 1ns / 1ps

module cum_div
    import cum_pkg::*;
#(
    parameter int NUM_W = 20,
    parameter int DEN_W = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   n_trial;
    logic             n_qbit;

    always_comb begin
        n_trial = {r_rem, r_num[NUM_W-1]};
        n_qbit  = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_qbit ? DEN_W'(n_trial - {1'b0, r_den}) : n_trial[DEN_W-1:0];
            r_num <= {r_num[NUM_W-2:0], n_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

FILE: rtl/cpu_utilization_monitor_top.sv
// cpu_utilization_monitor_top: hog counter, ring history walk, average and peak
// depends on cum_pkg and cum_div
//
//   channel  direction  handshake          payload
//   in       input      valid / stall      t_cum_in  (sample, sample_valid)
//   out      output     valid / stall      t_cum_out (average, peak, unknown, alarm)
//   cfg      input      valid / ready      index, data
//
// a known sample stalls the input while the walk does one read of the history memory per
// entry, then while the divider makes one bit per cycle, and until out takes the result
// an unknown sample skips the walk and the divider; one request is in work at a time
// reset is synchronous; the ring reads as zero through a fill count, no clearing pass
// the result register holds while out is stalled; the next request is taken meanwhile
`timescale 1ns / 1ps

module cpu_utilization_monitor_top
    import cum_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int UTIL_MAX      = UTIL_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_cum_in               i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_cum_out              o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);
    localparam int CW = $clog2(HISTORY_DEPTH + 2);
    localparam int SW = $clog2((HISTORY_DEPTH + 1) * UTIL_MAX + 1);
    localparam int MW = (CW > AVG_W) ? CW : AVG_W;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WALK  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_START = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;

    logic [UTIL_W-1:0]  r_hog_threshold;
    logic [LIMIT_W-1:0] r_hog_limit;
    logic               r_hog_enable;
    logic [AVG_W-1:0]   r_avg_count;

    logic [2:0]         r_state;
    logic [AW-1:0]      r_wp;
    logic [FW-1:0]      r_fill;
    logic [LIMIT_W-1:0] r_hog;
    logic               r_alarm;
    logic               r_unk;
    logic [UTIL_W-1:0]  r_cur;
    logic [SW-1:0]      r_sum;
    logic [CW-1:0]      r_cnt;
    logic [UTIL_W-1:0]  r_peak;
    logic [UTIL_W-1:0]  r_avg;
    logic [AW-1:0]      r_raddr;
    logic [AW-1:0]      r_walk;
    logic               r_rd_pend;
    logic               r_rd_ok;
    logic               r_out_valid;
    t_cum_out           r_out;

    logic [UTIL_W-1:0]  mem [HISTORY_DEPTH];
    logic [UTIL_W-1:0]  r_rdata;

    logic [UTIL_W-1:0]  n_cur;
    logic [UTIL_W-1:0]  n_hist;
    logic [AW-1:0]      n_raddr_dec;
    logic [AW-1:0]      n_start_addr;
    logic               mem_we;
    logic               out_free;
    logic               div_start;
    logic               div_done;
    logic [SW-1:0]      div_quot;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign div_start   = (r_state == ST_START);
    assign mem_we      = (r_state == ST_DIV) && div_done;

    always_comb begin
        n_cur        = (i_in.sample > SAMPLE_W'(UTIL_MAX)) ? UTIL_W'(UTIL_MAX)
                                                           : i_in.sample[UTIL_W-1:0];
        n_hist       = r_rd_ok ? r_rdata : '0;
        n_raddr_dec  = (r_raddr == '0) ? AW'(HISTORY_DEPTH - 1) : r_raddr - 1'b1;
        n_start_addr = (r_wp == '0) ? AW'(HISTORY_DEPTH - 1) : r_wp - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hog_threshold <= HOG_THRESHOLD_RST;
            r_hog_limit     <= HOG_LIMIT_RST;
            r_hog_enable    <= HOG_ENABLE_RST;
            r_avg_count     <= AVG_COUNT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HOG_THRESHOLD: r_hog_threshold <= i_cfg_data[UTIL_W-1:0];
                REG_HOG_LIMIT:     r_hog_limit     <= i_cfg_data[LIMIT_W-1:0];
                REG_HOG_ENABLE:    r_hog_enable    <= i_cfg_data[0];
                REG_AVG_COUNT:     r_avg_count     <= i_cfg_data[AVG_W-1:0];
                default: ;
            endcase
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_wp] <= r_cur;
        end
        r_rdata <= mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_hog       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= (r_state == ST_WALK);
            if ((r_state == ST_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_unk <= !i_in.sample_valid;
                        if (!i_in.sample_valid) begin
                            r_state <= ST_FIN;
                            r_alarm <= 1'b0;
                        end else begin
                            r_state <= ST_WALK;
                            r_cur   <= n_cur;
                            r_sum   <= SW'(n_cur);
                            r_cnt   <= CW'(1);
                            r_peak  <= n_cur;
                            r_raddr <= n_start_addr;
                            r_walk  <= '0;
                            if (r_hog_enable && (n_cur >= r_hog_threshold)) begin
                                if (r_hog != '1) begin
                                    r_hog   <= r_hog + 1'b1;
                                    r_alarm <= ((r_hog + 1'b1) == r_hog_limit);
                                end else begin
                                    r_alarm <= 1'b0;
                                end
                            end else begin
                                r_hog   <= '0;
                                r_alarm <= 1'b0;
                            end
                        end
                    end
                end
                ST_WALK: begin
                    r_rd_ok   <= (FW'(r_raddr) < r_fill);
                    r_raddr   <= n_raddr_dec;
                    r_walk    <= r_walk + 1'b1;
                    if (r_walk == AW'(HISTORY_DEPTH - 1)) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_START;
                end
                ST_START: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_avg   <= UTIL_W'(div_quot);
                        r_wp    <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        if (r_fill != FW'(HISTORY_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_state     <= ST_IDLE;
                        if (r_unk) begin
                            r_out <= '{util_average: '0, util_peak: '0,
                                       util_unknown: 1'b1, hog_alarm: 1'b0};
                        end else begin
                            r_out <= '{util_average: r_avg, util_peak: r_peak,
                                       util_unknown: 1'b0, hog_alarm: r_alarm};
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // accumulate history data in the cycle after each read: sum up to the average count, peak over all
            if (r_rd_pend) begin
                if (MW'(r_cnt) < MW'(r_avg_count)) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_sum <= r_sum + SW'(n_hist);
                end
                if (n_hist > r_peak) begin
                    r_peak <= n_hist;
                end
            end
        end
    end

    cum_div #(
        .NUM_W (SW),
        .DEN_W (CW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_sum),
        .i_den   (r_cnt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(HISTORY_DEPTH))
        else $error("fill count beyond ring depth");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == ST_DIV)
        else $error("divider finished outside divide step");

    a_peak_ge_avg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.util_unknown) |-> o_out.util_peak >= o_out.util_average)
        else $error("peak below average");

    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.util_unknown) |->
            (!o_out.hog_alarm && o_out.util_peak == '0 && o_out.util_average == '0))
        else $error("unknown result carries data");

    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> !mem_we && r_state == ST_FIN)
        else $error("ring written more than once per request");

endmodule
